FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check that holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// implication checked on the same edge
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// implication checked on the next edge
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: src/lssp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lssp_pkg;

  localparam int unsigned COORD_BITS_DEF = 11;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned NEAR_OFS = 15;
  localparam int unsigned FAR_OFS  = 30;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_LEFT_X_START  = 3'd0,
    REG_LEFT_Y_START  = 3'd1,
    REG_LEFT_X_END    = 3'd2,
    REG_LEFT_Y_END    = 3'd3,
    REG_RIGHT_X_START = 3'd4,
    REG_RIGHT_Y_START = 3'd5,
    REG_RIGHT_X_END   = 3'd6,
    REG_RIGHT_Y_END   = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

FILE: src/lane_scanline_sample_points_top.sv
// an input passes the stage-0, seed, divider, border and output registers in order
// throughput: one item per cycle unless stalled; one quotient bit per pipeline stage
// a stall at the output holds every stage until the result is taken
// reset clears all stage valid bits and the eight segment registers to zero
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lane_scanline_sample_points_top #(
  parameter int unsigned COORD_BITS = lssp_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = lssp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lssp_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [COORD_BITS-1:0]         scan_offset_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               valid_res_o,
  output logic [COORD_BITS:0]                row_o,
  output logic signed [COORD_BITS+1:0]       left_far_col_o,
  output logic signed [COORD_BITS+1:0]       left_near_col_o,
  output logic signed [COORD_BITS+1:0]       mark_col_o,
  output logic signed [COORD_BITS+1:0]       right_near_col_o,
  output logic signed [COORD_BITS+1:0]       right_far_col_o
);
  import lssp_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned Q     = COORD_BITS + FRAC_BITS;
  localparam int unsigned STEPS = Q;
  localparam int unsigned BW    = COORD_BITS + FRAC_BITS + 2;
  localparam int unsigned NPOS  = STEPS + 3;
  localparam logic signed [BW:0] NEAR_FX = (BW+1)'(NEAR_OFS) << FRAC_BITS;
  localparam logic signed [BW:0] FAR_FX  = (BW+1)'(FAR_OFS) << FRAC_BITS;

  typedef struct packed {
    logic          valid_res;
    logic [CB:0]   row;
  } meta_t;

  typedef struct packed {
    logic [CB-1:0] off;
    logic [CB-1:0] mag;
    logic [CB-1:0] dy;
    logic          neg;
  } prep_t;

  typedef struct packed {
    logic [CB:0]   rem;
    logic [CB-1:0] dvd;
    logic [Q-1:0]  quo;
    logic [CB-1:0] dy;
    logic          neg;
  } lane_t;

  // configuration registers
  logic [CB-1:0] cfg_q [NUM_REGS];
  logic          cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_wr) begin
      cfg_q[paddr[ADDR_BITS-1:2]] <= pwdata[CB-1:0];
    end
  end

  assign prdata = 32'(cfg_q[paddr[ADDR_BITS-1:2]]);

  logic [CB-1:0] lxs, lys, lxe, lye, rxs, rys, rxe, rye;
  assign lxs = cfg_q[REG_LEFT_X_START];
  assign lys = cfg_q[REG_LEFT_Y_START];
  assign lxe = cfg_q[REG_LEFT_X_END];
  assign lye = cfg_q[REG_LEFT_Y_END];
  assign rxs = cfg_q[REG_RIGHT_X_START];
  assign rys = cfg_q[REG_RIGHT_Y_START];
  assign rxe = cfg_q[REG_RIGHT_X_END];
  assign rye = cfg_q[REG_RIGHT_Y_END];

  // whole pipeline advances together
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic  vld_q  [NPOS];
  meta_t meta_q [NPOS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NPOS; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NPOS; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // stage 0: row, validity and segment deltas
  logic [CB-1:0] start_w;
  logic [CB:0]   row_w;
  meta_t         meta_d;
  prep_t         prep_l_d, prep_r_d, prep_l_q, prep_r_q;

  function automatic prep_t prep(logic [CB-1:0] xs, logic [CB-1:0] ys,
                                 logic [CB-1:0] xe, logic [CB-1:0] ye,
                                 logic [CB-1:0] rw);
    prep_t p;
    p.off = rw - ys;
    p.dy  = ye - ys;
    p.neg = xe < xs;
    p.mag = p.neg ? xs - xe : xe - xs;
    return p;
  endfunction

  always_comb begin
    start_w          = (lys > rys) ? lys : rys;
    row_w            = {1'b0, start_w} + {1'b0, scan_offset_i};
    meta_d.row       = row_w;
    meta_d.valid_res = (row_w < {1'b0, lye}) && (row_w < {1'b0, rye});
    prep_l_d         = prep(lxs, lys, lxe, lye, row_w[CB-1:0]);
    prep_r_d         = prep(rxs, rys, rxe, rye, row_w[CB-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_d;
      prep_l_q  <= prep_l_d;
      prep_r_q  <= prep_r_d;
      for (int i = 1; i < NPOS; i++) meta_q[i] <= meta_q[i-1];
    end
  end

  // stage 1: offset times |dx|, top half seeds the remainder
  lane_t div_q [STEPS+1][2];

  function automatic lane_t seed(prep_t p);
    lane_t         l;
    logic [2*CB-1:0] prod;
    prod  = p.off * p.mag;
    l.rem = {1'b0, prod[2*CB-1:CB]};
    l.dvd = prod[CB-1:0];
    l.quo = '0;
    l.dy  = p.dy;
    l.neg = p.neg;
    return l;
  endfunction

  function automatic lane_t div_step(lane_t a);
    lane_t       r;
    logic [CB:0] t;
    r     = a;
    t     = {a.rem[CB-1:0], a.dvd[CB-1]};
    r.dvd = a.dvd << 1;
    if (t >= {1'b0, a.dy}) begin
      r.rem = t - {1'b0, a.dy};
      r.quo = {a.quo[Q-2:0], 1'b1};
    end else begin
      r.rem = t;
      r.quo = {a.quo[Q-2:0], 1'b0};
    end
    return r;
  endfunction

  // seed, then one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0][0] <= seed(prep_l_q);
      div_q[0][1] <= seed(prep_r_q);
      for (int k = 0; k < STEPS; k++) begin
        div_q[k+1][0] <= div_step(div_q[k][0]);
        div_q[k+1][1] <= div_step(div_q[k][1]);
      end
    end
  end

  // border columns in fixed point
  logic signed [BW-1:0] bl_q, br_q;

  function automatic logic signed [BW-1:0] border(logic [CB-1:0] xs, lane_t l);
    logic signed [BW-1:0] base, q;
    base = signed'({2'b00, xs, {FRAC_BITS{1'b0}}});
    q    = signed'({2'b00, l.quo});
    return l.neg ? base - q : base + q;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      bl_q <= border(lxs, div_q[STEPS][0]);
      br_q <= border(rxs, div_q[STEPS][1]);
    end
  end

  function automatic logic [CB+1:0] trunc0(logic signed [BW:0] v, int unsigned k);
    logic [BW:0] m;
    m = v[BW] ? -v : v;
    m = m >> k;
    m = v[BW] ? -m : m;
    return m[CB+1:0];
  endfunction

  logic signed [BW:0] blx, brx;
  assign blx = {bl_q[BW-1], bl_q};
  assign brx = {br_q[BW-1], br_q};

  // output register
  logic                 vres_q;
  logic [CB:0]          row_q;
  logic signed [CB+1:0] lf_q, ln_q, mk_q, rn_q, rf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[NPOS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vres_q <= meta_q[NPOS-1].valid_res;
      row_q  <= meta_q[NPOS-1].row;
      if (meta_q[NPOS-1].valid_res) begin
        lf_q <= signed'(trunc0(blx - FAR_FX, FRAC_BITS));
        ln_q <= signed'(trunc0(blx - NEAR_FX, FRAC_BITS));
        mk_q <= signed'(trunc0(blx + brx, FRAC_BITS + 1));
        rn_q <= signed'(trunc0(brx + NEAR_FX, FRAC_BITS));
        rf_q <= signed'(trunc0(brx + FAR_FX, FRAC_BITS));
      end else begin
        lf_q <= '0;
        ln_q <= '0;
        mk_q <= '0;
        rn_q <= '0;
        rf_q <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign valid_res_o      = vres_q;
  assign row_o            = row_q;
  assign left_far_col_o   = lf_q;
  assign left_near_col_o  = ln_q;
  assign mark_col_o       = mk_q;
  assign right_near_col_o = rn_q;
  assign right_far_col_o  = rf_q;

  `ASSERT_IMPLY(a_invalid_zero, clk_i, rst_ni, out_valid_q && !vres_q,
                lf_q == '0 && mk_q == '0 && rf_q == '0)
  `ASSERT_IMPLY(a_row_in_range, clk_i, rst_ni, out_valid_q && vres_q,
                row_q < {1'b0, lye} && row_q < {1'b0, rye})
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_q && !out_ready_i,
               out_valid_q && $stable(vld_q[NPOS-1]))
  `ASSERT_ALWAYS(a_ready_rule, clk_i, rst_ni, in_ready_o == (!out_valid_q || out_ready_i))

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import lssp_pkg::*;

  localparam int CB = 11;
  localparam int FB = 16;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic        vld;
    logic [11:0] row;
    logic [12:0] lfar;
    logic [12:0] lnear;
    logic [12:0] mark;
    logic [12:0] rnear;
    logic [12:0] rfar;
  } samples_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [CB-1:0] scan_offset_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic valid_res_o;
  logic [CB:0] row_o;
  logic signed [CB+1:0] left_far_col_o, left_near_col_o, mark_col_o;
  logic signed [CB+1:0] right_near_col_o, right_far_col_o;

  lane_scanline_sample_points_top dut (.*);

  always #5 clk_i = ~clk_i;

  logic [CB-1:0] seg_reg [NUM_REGS];
  samples_t expected_q [$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet_stretch = 0;
  int hold_cycles = 0;

  // border column in fixed point, row >= ys and ye > ys assumed
  function automatic longint border_col(int xs, int ys, int xe, int ye, int row);
    longint dx, mag, q;
    dx = xe - xs;
    mag = dx < 0 ? -dx : dx;
    q = ((longint'(row - ys) * mag) <<< FB) / (ye - ys);
    return dx < 0 ? (longint'(xs) <<< FB) - q : (longint'(xs) <<< FB) + q;
  endfunction

  function automatic longint trunc0(longint v, int k);
    return v < 0 ? -((-v) >>> k) : (v >>> k);
  endfunction

  function automatic samples_t predict_samples(logic [CB-1:0] ofs);
    samples_t s;
    int lys, rys, row;
    longint bl, br, one;
    lys = seg_reg[REG_LEFT_Y_START];
    rys = seg_reg[REG_RIGHT_Y_START];
    row = (lys > rys ? lys : rys) + ofs;
    s = '0;
    s.row = row[11:0];
    s.vld = row < seg_reg[REG_LEFT_Y_END] && row < seg_reg[REG_RIGHT_Y_END];
    if (s.vld) begin
      one = longint'(1) <<< FB;
      bl = border_col(seg_reg[REG_LEFT_X_START], lys, seg_reg[REG_LEFT_X_END],
                      seg_reg[REG_LEFT_Y_END], row);
      br = border_col(seg_reg[REG_RIGHT_X_START], rys, seg_reg[REG_RIGHT_X_END],
                      seg_reg[REG_RIGHT_Y_END], row);
      s.lfar  = 13'(trunc0(bl - FAR_OFS * one, FB));
      s.lnear = 13'(trunc0(bl - NEAR_OFS * one, FB));
      s.mark  = 13'(trunc0(bl + br, FB + 1));
      s.rnear = 13'(trunc0(br + NEAR_OFS * one, FB));
      s.rfar  = 13'(trunc0(br + FAR_OFS * one, FB));
    end
    return s;
  endfunction

  function automatic bit idle_now();
    return !quiet_stretch && ($urandom_range(99) < 11);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= rst_ni && !idle_now();
    end
  end

  // result checker
  always @(posedge clk_i) begin
    samples_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {valid_res_o, row_o, left_far_col_o, left_near_col_o, mark_col_o,
             right_near_col_o, right_far_col_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [CB-1:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_BITS'(4 * idx); pwdata <= 32'(val);
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    seg_reg[idx] = val;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid stays up after a transfer so back to back items need no gap
  task automatic send_offset(logic [CB-1:0] ofs);
    while (idle_now()) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    scan_offset_i <= ofs;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_samples(ofs));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_segments(int lxs, int lys, int lxe, int lye,
                              int rxs, int rys, int rxe, int rye);
    drain();
    write_reg(REG_LEFT_X_START, CB'(lxs));  write_reg(REG_LEFT_Y_START, CB'(lys));
    write_reg(REG_LEFT_X_END, CB'(lxe));    write_reg(REG_LEFT_Y_END, CB'(lye));
    write_reg(REG_RIGHT_X_START, CB'(rxs)); write_reg(REG_RIGHT_Y_START, CB'(rys));
    write_reg(REG_RIGHT_X_END, CB'(rxe));   write_reg(REG_RIGHT_Y_END, CB'(rye));
  endtask

  task automatic test_reset_values();
    send_offset(0);
    send_offset(11'h7ff);
  endtask

  task automatic test_extremes();
    // steep borders to the image edges, full height
    set_segments(2047, 0, 0, 2047, 0, 0, 2047, 2047);
    send_offset(0); send_offset(1); send_offset(2046); send_offset(2047);
    send_offset(11'h555); send_offset(11'h2aa);
    // borders near column zero give negative samples
    set_segments(0, 10, 5, 2000, 3, 5, 0, 1500);
    send_offset(0); send_offset(1489); send_offset(1490); send_offset(700);
    // zero and negative dy give no samples
    set_segments(100, 500, 200, 500, 300, 400, 400, 300);
    send_offset(0); send_offset(5);
    // single valid row, vertical borders
    set_segments(1000, 7, 1000, 8, 1100, 3, 1100, 8);
    send_offset(0); send_offset(1);
  endtask

  task automatic test_random_segments();
    int ys, n;
    for (int ph = 0; ph < 12; ph++) begin
      ys = $urandom_range(1800);
      set_segments($urandom_range(2047), ys, $urandom_range(2047),
                   ys + $urandom_range(2047 - ys),
                   $urandom_range(2047), $urandom_range(ys), $urandom_range(2047),
                   ph == 5 ? $urandom_range(2047) : ys + $urandom_range(2047 - ys));
      quiet_stretch = (ph == 3);
      n = 0;
      while (n < 50) begin
        if ($urandom_range(9) < 8) send_offset(CB'($urandom_range(300)));
        else send_offset(CB'($urandom()));
        n++;
      end
      quiet_stretch = 0;
    end
  endtask

  task automatic test_backpressure();
    set_segments(100, 0, 1900, 2000, 1900, 0, 100, 2000);
    @(negedge clk_i);
    hold_cycles <= 150;
    for (int i = 0; i < 60; i++) send_offset(CB'($urandom()));
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) seg_reg[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    test_reset_values();
    test_extremes();
    test_random_segments();
    test_backpressure();
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
